@@ rtl/core/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// shared widths, constants and controller/datapath types of the k-way merge
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int VAL_W         = 32;
    localparam int SRC_W         = 3;
    localparam int CFG_W         = 4;
    // lists reachable through the source field
    localparam int SRC_SLOTS     = 1 << SRC_W;
    localparam int MAX_LISTS_DEF = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;     // take the input item this cycle
        logic scan_step;  // compare one held head
        logic emit;       // load the output register with the minimum
    } t_cmd;

    typedef struct packed {
        logic scan_last;  // current scan slot is the last active list
        logic result_ok;  // all active lists filled or done, some head held
        logic out_free;   // output register empty or being taken
    } t_status;

endpackage

@@ rtl/core/kwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// kwm_ctrl
// sequencer: take one item, scan the held heads, emit the minimum
// ----------------------------------------------------------------------------
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.result_ok) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/kwm_datapath.sv @@
// ----------------------------------------------------------------------------
// kwm_datapath
// head store, done flags, sequential minimum search and output register
// ----------------------------------------------------------------------------
module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS = MAX_LISTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic [SRC_W-1:0]        i_source,
    input  logic                    i_list_end,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_merged_value,
    output logic [SRC_W-1:0]        o_from_list
);

    localparam int NUM_SLOTS = (MAX_LISTS < SRC_SLOTS) ? MAX_LISTS : SRC_SLOTS;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [CFG_W-1:0] SLOTS_C = CFG_W'(NUM_SLOTS);

    logic [CFG_W-1:0]        r_cfg;
    logic [VAL_W-1:0]        r_head [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    r_held;
    logic [NUM_SLOTS-1:0]    r_done;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_best_idx;
    logic signed [VAL_W-1:0] r_best_val;
    logic                    r_any;
    logic                    r_ready;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_val;
    logic [SRC_W-1:0]        r_out_src;

    logic [CFG_W-1:0]        active;
    logic [CFG_W-1:0]        cfg_min1;
    logic [IDX_W-1:0]        src_idx;
    logic                    src_ok;
    logic signed [VAL_W-1:0] cur_val;
    logic                    take_cur;

    // zero counts as one, then saturate to the available slots
    assign cfg_min1 = (r_cfg == '0) ? CFG_W'(1) : r_cfg;
    assign active   = (cfg_min1 > SLOTS_C) ? SLOTS_C : cfg_min1;

    assign src_idx = i_source[IDX_W-1:0];
    assign src_ok  = (CFG_W'(i_source) < active) && !r_held[src_idx] && !r_done[src_idx];

    assign cur_val  = $signed(r_head[r_idx]);
    assign take_cur = r_held[r_idx] && (!r_any || (cur_val < r_best_val));

    assign o_status.scan_last = (CFG_W'(r_idx) == (active - CFG_W'(1)));
    assign o_status.result_ok = r_ready && r_any;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_held      <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_ready     <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_idx   <= '0;
                r_any   <= 1'b0;
                r_ready <= 1'b1;
                if (src_ok) begin
                    if (i_list_end) begin
                        r_done[src_idx] <= 1'b1;
                    end else begin
                        r_held[src_idx] <= 1'b1;
                    end
                end
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_held[r_idx]) begin
                    r_any <= 1'b1;
                end else if (!r_done[r_idx]) begin
                    r_ready <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_held[r_best_idx] <= 1'b0;
                r_out_valid        <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && src_ok && !i_list_end) begin
            r_head[src_idx] <= i_element_value;
        end
        // strict less-than keeps the lower list on ties
        if (i_cmd.scan_step && take_cur) begin
            r_best_idx <= r_idx;
            r_best_val <= cur_val;
        end
        if (i_cmd.emit) begin
            r_out_val <= r_best_val;
            r_out_src <= SRC_W'(r_best_idx);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_val;
    assign o_from_list    = r_out_src;

endmodule

@@ rtl/core/k_way_sorted_merge_unit.sv @@
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// merges ascending source lists into one ascending stream by min-select
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_element_value, i_source, i_list_end
//  out     | output    | o_out_valid / i_out_stall   | o_merged_value, o_from_list
//  cfg     | input     | i_cfg_we                    | i_cfg_data (lists_in_use)
//
//  each item is handled in order: take it, scan the active lists one after another for
//  the minimum over the held heads, then load the output register.
//  the output register is separate, so the next item is taken while a result waits;
//  a stalled output only holds the block at the end of the following scan.
//  synchronous active-low reset clears heads held, done flags and lists_in_use to 8.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_unit
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS = MAX_LISTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic [SRC_W-1:0]        i_source,
    input  logic                    i_list_end,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_merged_value,
    output logic [SRC_W-1:0]        o_from_list
);

    t_cmd    cmd;
    t_status status;

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kwm_datapath #(
        .MAX_LISTS (MAX_LISTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_element_value (i_element_value),
        .i_source        (i_source),
        .i_list_end      (i_list_end),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_merged_value  (o_merged_value),
        .o_from_list     (o_from_list)
    );

endmodule

@@ test/kwm_merge_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_checker
// watches the config port and both channels of the k-way merge, keeps its own
// copy of the held heads and done flags, predicts each merged item at input
// acceptance and compares every accepted output item against the oldest one
// ----------------------------------------------------------------------------
module kwm_merge_checker
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS = MAX_LISTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  logic [SRC_W-1:0]        i_source,
    input  logic                    i_list_end,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [VAL_W-1:0] i_merged_value,
    input  logic [SRC_W-1:0]        i_from_list,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [SRC_W-1:0]        list;
    } t_merged;

    logic signed [VAL_W-1:0] head_val [SRC_SLOTS];
    logic [SRC_SLOTS-1:0]    head_held;
    logic [SRC_SLOTS-1:0]    list_over;
    logic [CFG_W-1:0]        lists_cfg;
    t_merged                 merged_due [$];
    t_merged                 oldest;
    int                      fail_cnt = 0;

    // register value to number of lists taking part
    function automatic int lists_taking_part(input logic [CFG_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n < 1) n = 1;
        if (n > MAX_LISTS) n = MAX_LISTS;
        if (n > SRC_SLOTS) n = SRC_SLOTS;
        return n;
    endfunction

    // take one item, then pick the smallest head once every active list is settled
    task automatic take_and_pick_min(input logic signed [VAL_W-1:0] val,
                                     input logic [SRC_W-1:0] src, input logic last);
        int      n;
        int      i;
        int      best;
        bit      ready;
        bit      any;
        t_merged m;
        n     = lists_taking_part(lists_cfg);
        ready = 1'b1;
        any   = 1'b0;
        best  = 0;
        if (int'(src) < n && !head_held[src] && !list_over[src]) begin
            if (last) begin
                list_over[src] = 1'b1;
            end else begin
                head_val[src]  = val;
                head_held[src] = 1'b1;
            end
        end
        for (i = 0; i < n; i++) begin
            if (head_held[i]) begin
                // strict less keeps the lower list on ties
                if (!any || head_val[i] < head_val[best]) best = i;
                any = 1'b1;
            end else if (!list_over[i]) begin
                ready = 1'b0;
            end
        end
        if (ready && any) begin
            head_held[best] = 1'b0;
            m.value = head_val[best];
            m.list  = SRC_W'(best);
            merged_due.insert(merged_due.size(), m);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_held = '0;
            list_over = '0;
            lists_cfg = CFG_RESET;
            merged_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (merged_due.size() == 0) begin
                    $error("unexpected output item: merged_value %0d from_list %0d",
                           i_merged_value, i_from_list);
                    fail_cnt++;
                end else begin
                    oldest = merged_due.pop_front();
                    if (i_merged_value !== oldest.value) begin
                        $error("merged_value: expected %0d, actual %0d",
                               oldest.value, i_merged_value);
                        fail_cnt++;
                    end
                    if (i_from_list !== oldest.list) begin
                        $error("from_list: expected %0d, actual %0d",
                               oldest.list, i_from_list);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_and_pick_min(i_element_value, i_source, i_list_end);
            end
            if (i_cfg_we) lists_cfg = i_cfg_data;
        end
        o_fail_count <= fail_cnt;
        o_pending    <= merged_due.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the k-way merge with directed corner items and then with refill
// sequences steered by the merged output, under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_top;
    import kwm_pkg::*;

    localparam int LISTS     = MAX_LISTS_DEF;
    localparam int SETTLE    = 2 * (LISTS + 2) + 4;
    localparam int PHASE_LEN = 230;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    cfg_we          = 1'b0;
    logic [CFG_W-1:0]        cfg_data        = '0;
    logic                    in_valid        = 1'b0;
    logic signed [VAL_W-1:0] element_value   = '0;
    logic [SRC_W-1:0]        source          = '0;
    logic                    list_end        = 1'b0;
    logic                    out_stall       = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [VAL_W-1:0] o_merged_value;
    logic [SRC_W-1:0]        o_from_list;
    int                      fail_count;
    int                      pending;

    // stimulus-side view of the lists
    logic [LISTS-1:0]        want  = '1;
    logic [LISTS-1:0]        ended = '0;
    logic signed [VAL_W-1:0] last_val [LISTS];
    int                      n_act   = LISTS;
    bit                      idle_on = 1'b1;
    int                      freed_q [$];

    // receiver state
    int rx_wait   = 0;
    int rx_taken  = 0;
    int hold_left = 0;

    k_way_sorted_merge_unit #(
        .MAX_LISTS(LISTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_element_value(element_value),
        .i_source       (source),
        .i_list_end     (list_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_merged_value (o_merged_value),
        .o_from_list    (o_from_list)
    );

    kwm_merge_checker #(
        .MAX_LISTS(LISTS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_element_value(element_value),
        .i_source       (source),
        .i_list_end     (list_end),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_merged_value (o_merged_value),
        .i_from_list    (o_from_list),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // receiver: random wait after each item while gaps are on, plus two long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                rx_taken++;
                rx_wait = idle_on ? $urandom_range(0, 4) : 0;
                if (rx_taken == 300 || rx_taken == 700) hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // an output item about to be taken names the list to refill
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            freed_q.insert(freed_q.size(), int'(o_from_list));
        end
    end

    task automatic pause_cycle();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic signed [VAL_W-1:0] val, input logic [SRC_W-1:0] src,
                             input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        element_value <= val;
        source        <= src;
        list_end      <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic write_lists(input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        n_act = (val == 0) ? 1 : ((val > LISTS) ? LISTS : int'(val));
    endtask

    // wait until every merged item is out and the block has gone quiet
    task automatic settle_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic take_freed();
        int s;
        while (freed_q.size() > 0) begin
            s = freed_q.pop_front();
            want[s]  = 1'b1;
            // a list that comes out again was never really ended
            ended[s] = 1'b0;
        end
    endtask

    task automatic run_merge_phase(input logic [CFG_W-1:0] cfg, input bit gaps);
        int                      made;
        int                      s;
        logic [LISTS-1:0]        cand;
        logic [LISTS-1:0]        act_mask;
        logic signed [VAL_W-1:0] v;
        logic                    e;
        pause_cycle();
        settle_idle();
        write_lists(cfg);
        idle_on  = gaps;
        want     = ~ended;
        act_mask = LISTS'((1 << n_act) - 1);
        made     = 0;
        while (made < PHASE_LEN) begin
            take_freed();
            cand = want & ~ended & act_mask;
            if (cand != 0 && $urandom_range(0, 9) < 8) begin
                do s = $urandom_range(0, LISTS - 1); while (!cand[s]);
                want[s] = 1'b0;
                // lists 0 and 1 stay alive so the merge keeps going
                e = (s >= 2) && ($urandom_range(0, 299) == 0);
                case ($urandom_range(0, 9))
                    0:       v = $urandom;
                    1:       v = last_val[$urandom_range(0, LISTS - 1)];
                    2:       v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                    default: v = last_val[s] + $urandom_range(0, 1 << $urandom_range(0, 24));
                endcase
                if (e) ended[s] = 1'b1;
                else last_val[s] = v;
                send_item(v, SRC_W'(s), e);
                made++;
            end else if ($urandom_range(0, 1)) begin
                // noise: stray values, end markers only where they cannot end a live list
                s = $urandom_range(0, LISTS - 1);
                e = (s >= n_act || ended[s]) ? 1'($urandom_range(0, 1)) : 1'b0;
                if (s < n_act && !e) want[s] = 1'b0;
                send_item($urandom, SRC_W'(s), e);
                made++;
            end else begin
                pause_cycle();
            end
        end
    endtask

    initial begin
        logic [LISTS-1:0] cand;
        int               s;
        int               p;
        logic [CFG_W-1:0] cfg_seq [8];
        cfg_seq = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd9};
        foreach (last_val[i]) last_val[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners with lists 0..2 active
        write_lists(4'd3);
        send_item(32'sd123, 3'd5, 1'b0);   // inactive source
        send_item(-32'sd5, 3'd7, 1'b1);    // inactive end marker
        send_item(32'sd9, 3'd6, 1'b0);
        send_item(VAL_MIN, 3'd0, 1'b0);
        send_item(VAL_MAX, 3'd1, 1'b0);
        send_item(VAL_MIN, 3'd2, 1'b0);    // tie on the minimum, lower list wins
        send_item(32'sd0, 3'd1, 1'b0);     // head already held
        send_item(32'sd0, 3'd1, 1'b1);     // end marker on a held head
        send_item(-32'sd1, 3'd0, 1'b0);
        send_item(32'sd0, 3'd2, 1'b1);     // list 2 ends
        send_item(32'sd5, 3'd2, 1'b0);     // item for a done list
        send_item(32'sd5, 3'd2, 1'b1);
        send_item(VAL_MAX, 3'd0, 1'b0);    // tie on the maximum
        send_item(32'sd7, 3'd0, 1'b0);
        send_item(VAL_MAX, 3'd0, 1'b0);
        ended[2] = 1'b1;

        for (p = 0; p < 8; p++) run_merge_phase(cfg_seq[p], p % 2 == 0);

        // end every list, draining held heads as they come out
        pause_cycle();
        settle_idle();
        write_lists(4'd8);
        idle_on = 1'b1;
        want    = ~ended;
        while (ended != '1 || freed_q.size() != 0 || pending != 0) begin
            take_freed();
            cand = want & ~ended;
            if (cand != 0) begin
                do s = $urandom_range(0, LISTS - 1); while (!cand[s]);
                want[s]  = 1'b0;
                ended[s] = 1'b1;
                send_item($urandom, SRC_W'(s), 1'b1);
            end
            pause_cycle();
        end
        // all lists done: nothing more may come out
        repeat (6) send_item($urandom, SRC_W'($urandom_range(0, LISTS - 1)),
                             1'($urandom_range(0, 1)));
        pause_cycle();
        settle_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
